// ===== rtl/dotpi_pkg.sv =====
// Shared widths, register codes, reset values and polynomial constants of the dot pattern core.
package dotpi_pkg;

  localparam int COORD_W    = 24;
  localparam int PERIOD_W   = 16;
  localparam int EXT_W      = 23;
  localparam int GRID_W     = 7;
  localparam int IDX_W      = 6;
  localparam int INT_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;
  localparam int PHASE_BITS_DEF = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD      = 3'd0,
    REG_HALF_WIDTH  = 3'd1,
    REG_HALF_HEIGHT = 3'd2,
    REG_ORIGIN_X    = 3'd3,
    REG_ORIGIN_Y    = 3'd4,
    REG_GRID_ROWS   = 3'd5,
    REG_GRID_COLS   = 3'd6
  } cfg_reg_t;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd256;
  localparam logic [EXT_W-1:0]    HALF_RST   = 23'h7FFFFF;
  localparam logic [GRID_W-1:0]   GRID_RST   = 7'd1;

  // Cosine Taylor coefficients in Q30, Horner order after the innermost term.
  localparam logic signed [64:0] CO5_NEG = -65'sd27060;
  localparam logic signed [64:0] Q30_ONE = 65'sd1073741824;
  localparam logic signed [64:0] HORNER_C [5] = '{
    65'sd987049, -65'sd22401991, 65'sd272375562, -65'sd1324675880, 65'sd1073741824
  };

  localparam logic [INT_W-1:0] INT_ONE = 17'd65536;

endpackage

// ===== rtl/dotpi_req_if.sv =====
// Input channel: load or query word with valid/ready handshake.
interface dotpi_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic [dotpi_pkg::IDX_W-1:0]          row_index;
  logic [dotpi_pkg::IDX_W-1:0]          col_index;
  logic                                 bit_value;
  logic signed [dotpi_pkg::COORD_W-1:0] x_pos;
  logic signed [dotpi_pkg::COORD_W-1:0] y_pos;

  modport source (output valid, req_type, row_index, col_index, bit_value, x_pos, y_pos,
                  input ready);
  modport sink   (input valid, req_type, row_index, col_index, bit_value, x_pos, y_pos,
                  output ready);
endinterface

// ===== rtl/dotpi_res_if.sv =====
// Result channel: intensity word with valid/ready handshake.
interface dotpi_res_if;
  logic                        valid;
  logic                        ready;
  logic [dotpi_pkg::INT_W-1:0] intensity;
  logic                        in_grid;

  modport source (output valid, intensity, in_grid, input ready);
  modport sink   (input valid, intensity, in_grid, output ready);
endinterface

// ===== rtl/dotpi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dotpi_ram #(
  parameter int W     = 1,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                              wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                              rdata
);
  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/dot_pattern_intensity_core.sv =====
// Dot pattern intensity core: pipelined divider, phase, cosine polynomial and product stages.
// The divider stages are a 25-step and a PHASE_BITS-step restoring divider chain.
// Throughput: one word per clock; the whole pipeline holds while the output word waits.
// Reset (rst_n low, synchronous) clears all valid bits and loads register reset values;
// the dot map is not cleared and reads undefined until written.
module dot_pattern_intensity_core #(
  parameter int MAX_ROWS   = dotpi_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = dotpi_pkg::MAX_COLS_DEF,
  parameter int PHASE_BITS = dotpi_pkg::PHASE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  dotpi_req_if.sink                           in_req,
  dotpi_res_if.source                         out_res,
  input  logic                                cfg_we,
  input  logic [dotpi_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [dotpi_pkg::CFG_DATA_W-1:0]    cfg_data
);
  localparam int CRD   = dotpi_pkg::COORD_W;
  localparam int DW    = CRD + 1;
  localparam int PW    = dotpi_pkg::PERIOD_W;
  localparam int PB    = PHASE_BITS;
  localparam int KW    = PB - 2;
  localparam int QS    = 1 << KW;
  localparam int SH    = 30 - 2 * KW;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int ST_C   = DW + 1;
  localparam int ST_P   = ST_C + PB + 1;
  localparam int ST_SQ  = ST_P + 1;
  localparam int ST_RD  = ST_SQ + 11;
  localparam int ST_MP  = ST_RD + 1;
  localparam int ST_OUT = ST_MP + 1;
  localparam int NST    = ST_OUT + 1;

  typedef struct packed {
    logic          valid;
    logic          query;
    logic          gok;
    logic          dot;
    logic          wok;
    logic          wbit;
    logic [AW-1:0] addr;
  } ctl_t;

  // Configuration registers.
  logic [PW-1:0]                       period_r;
  logic [dotpi_pkg::EXT_W-1:0]         half_w_r, half_h_r;
  logic signed [CRD-1:0]               org_x_r, org_y_r;
  logic [dotpi_pkg::GRID_W-1:0]        rows_r, cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= dotpi_pkg::PERIOD_RST;
      half_w_r <= dotpi_pkg::HALF_RST;
      half_h_r <= dotpi_pkg::HALF_RST;
      org_x_r  <= '0;
      org_y_r  <= '0;
      rows_r   <= dotpi_pkg::GRID_RST;
      cols_r   <= dotpi_pkg::GRID_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        dotpi_pkg::REG_PERIOD:      period_r <= cfg_data[PW-1:0];
        dotpi_pkg::REG_HALF_WIDTH:  half_w_r <= cfg_data[dotpi_pkg::EXT_W-1:0];
        dotpi_pkg::REG_HALF_HEIGHT: half_h_r <= cfg_data[dotpi_pkg::EXT_W-1:0];
        dotpi_pkg::REG_ORIGIN_X:    org_x_r  <= $signed(cfg_data[CRD-1:0]);
        dotpi_pkg::REG_ORIGIN_Y:    org_y_r  <= $signed(cfg_data[CRD-1:0]);
        dotpi_pkg::REG_GRID_ROWS:   rows_r   <= cfg_data[dotpi_pkg::GRID_W-1:0];
        dotpi_pkg::REG_GRID_COLS:   cols_r   <= cfg_data[dotpi_pkg::GRID_W-1:0];
        default: ;
      endcase
    end
  end

  ctl_t ctl_r [NST];
  logic adv;

  assign adv          = !ctl_r[ST_OUT].valid || out_res.ready;
  assign in_req.ready = adv;

  // Entry stage: extents test, origin sums and divider operands.
  ctl_t                  ctl_s0;
  logic signed [DW-1:0]  sx, sy, xw, yw, hw25, hh25;
  logic                  ext_ok;
  logic [DW-1:0]         mag_s0 [4];
  logic                  neg_s0 [4];

  always_comb begin
    xw   = DW'(in_req.x_pos);
    yw   = DW'(in_req.y_pos);
    sx   = xw + DW'(org_x_r);
    sy   = yw + DW'(org_y_r);
    hw25 = $signed({2'b00, half_w_r});
    hh25 = $signed({2'b00, half_h_r});
    ext_ok = (period_r != '0) && (xw <= hw25) && (xw >= -hw25) && (yw <= hh25) && (yw >= -hh25);
    neg_s0[0] = xw[DW-1];
    neg_s0[1] = yw[DW-1];
    neg_s0[2] = sx[DW-1];
    neg_s0[3] = sy[DW-1];
    // Negative dividends run as ~a; the correction stage recovers the floor remainder.
    mag_s0[0] = xw[DW-1] ? ~xw : xw;
    mag_s0[1] = yw[DW-1] ? ~yw : yw;
    mag_s0[2] = sx[DW-1] ? ~sx : sx;
    mag_s0[3] = sy[DW-1] ? ~sy : sy;
    ctl_s0.valid = in_req.valid;
    ctl_s0.query = in_req.req_type;
    ctl_s0.gok   = in_req.req_type && ext_ok;
    ctl_s0.dot   = 1'b0;
    ctl_s0.wok   = (32'(in_req.row_index) < MAX_ROWS) && (32'(in_req.col_index) < MAX_COLS);
    ctl_s0.wbit  = in_req.bit_value;
    ctl_s0.addr  = AW'(32'(in_req.row_index) * MAX_COLS + 32'(in_req.col_index));
  end

  // Integer divider chain, one quotient bit per stage, four lanes.
  logic [PW-1:0] drem_r [DW+1][4];
  logic [DW-1:0] ddvd_r [DW+1][4];
  logic [DW-1:0] dquo_r [DW+1][4];
  logic          dneg_r [DW+1][4];
  logic [PW-1:0] drem_nxt [DW+1][4];
  logic [DW-1:0] dquo_nxt [DW+1][4];
  logic [PW:0]   drs [DW+1][4];

  always_comb begin
    for (int s = 0; s <= DW; s++) begin
      for (int l = 0; l < 4; l++) begin
        drem_nxt[s][l] = '0;
        dquo_nxt[s][l] = '0;
        drs[s][l]      = '0;
      end
    end
    for (int s = 1; s <= DW; s++) begin
      for (int l = 0; l < 4; l++) begin
        drs[s][l] = {drem_r[s-1][l], ddvd_r[s-1][l][DW-1]};
        if (drs[s][l] >= {1'b0, period_r}) begin
          drem_nxt[s][l] = PW'(drs[s][l] - {1'b0, period_r});
          dquo_nxt[s][l] = {dquo_r[s-1][l][DW-2:0], 1'b1};
        end else begin
          drem_nxt[s][l] = drs[s][l][PW-1:0];
          dquo_nxt[s][l] = {dquo_r[s-1][l][DW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        drem_r[0][l] <= '0;
        ddvd_r[0][l] <= mag_s0[l];
        dquo_r[0][l] <= '0;
        dneg_r[0][l] <= neg_s0[l];
      end
      for (int s = 1; s <= DW; s++) begin
        for (int l = 0; l < 4; l++) begin
          drem_r[s][l] <= drem_nxt[s][l];
          ddvd_r[s][l] <= ddvd_r[s-1][l] << 1;
          dquo_r[s][l] <= dquo_nxt[s][l];
          dneg_r[s][l] <= dneg_r[s-1][l];
        end
      end
    end
  end

  // Correction stage: floor remainders for the phase, cell indexes and grid test.
  ctl_t          ctl_c;
  logic [DW-1:0] col_lim, row_lim;
  logic [PW-1:0] rem_c [2];

  always_comb begin
    col_lim = (32'(cols_r) < MAX_COLS) ? DW'(cols_r) : DW'(MAX_COLS);
    row_lim = (32'(rows_r) < MAX_ROWS) ? DW'(rows_r) : DW'(MAX_ROWS);
    for (int l = 0; l < 2; l++) begin
      rem_c[l] = dneg_r[DW][l] ? (period_r - PW'(1) - drem_r[DW][l]) : drem_r[DW][l];
    end
    ctl_c = ctl_r[DW];
    if (ctl_r[DW].query) begin
      ctl_c.gok  = ctl_r[DW].gok && !dneg_r[DW][2] && !dneg_r[DW][3] &&
                   (dquo_r[DW][2] < col_lim) && (dquo_r[DW][3] < row_lim);
      ctl_c.addr = AW'(32'(dquo_r[DW][3][RW-1:0]) * MAX_COLS + 32'(dquo_r[DW][2][CW-1:0]));
    end
  end

  // Fractional divider chain: phase = floor(r * 2^PB / period).
  logic [PW-1:0] prem_r [PB+1][2];
  logic [PB-1:0] pph_r  [PB+1][2];
  logic [PW-1:0] prem_nxt [PB+1][2];
  logic [PB-1:0] pph_nxt  [PB+1][2];
  logic [PW:0]   prs [PB+1][2];

  always_comb begin
    for (int s = 0; s <= PB; s++) begin
      for (int l = 0; l < 2; l++) begin
        prem_nxt[s][l] = '0;
        pph_nxt[s][l]  = '0;
        prs[s][l]      = '0;
      end
    end
    for (int s = 1; s <= PB; s++) begin
      for (int l = 0; l < 2; l++) begin
        prs[s][l] = {prem_r[s-1][l], 1'b0};
        if (prs[s][l] >= {1'b0, period_r}) begin
          prem_nxt[s][l] = PW'(prs[s][l] - {1'b0, period_r});
          pph_nxt[s][l]  = {pph_r[s-1][l][PB-2:0], 1'b1};
        end else begin
          prem_nxt[s][l] = prs[s][l][PW-1:0];
          pph_nxt[s][l]  = {pph_r[s-1][l][PB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        prem_r[0][l] <= rem_c[l];
        pph_r[0][l]  <= '0;
      end
      for (int s = 1; s <= PB; s++) begin
        for (int l = 0; l < 2; l++) begin
          prem_r[s][l] <= prem_nxt[s][l];
          pph_r[s][l]  <= pph_nxt[s][l];
        end
      end
    end
  end

  // Quadrant folding, square, Horner polynomial, amplitude and product.
  logic [KW:0]            kk_r [2];
  logic                   cneg_r [2];
  logic [30:0]            ht_r [11][2];
  logic                   hneg_r [11][2];
  logic signed [64:0]     hv_r [11][2];
  logic signed [64:0]     hv_nxt [11][2];
  logic [17:0]            amp_r [2];
  logic [35:0]            prod_r;
  logic [dotpi_pkg::INT_W-1:0] int_r;
  logic                   ing_r;

  logic [1:0]             quad [2];
  logic [KW:0]            kk_nxt [2];
  logic [30:0]            cl [2];
  logic [dotpi_pkg::INT_W-1:0] ent [2];
  logic [18:0]            rnd;
  logic [dotpi_pkg::INT_W-1:0] sat;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quad[l]   = pph_r[PB][l][PB-1:PB-2];
      kk_nxt[l] = quad[l][0] ? ((KW+1)'(QS) - {1'b0, pph_r[PB][l][KW-1:0]})
                             : {1'b0, pph_r[PB][l][KW-1:0]};
    end
    for (int i = 0; i <= 10; i++) begin
      for (int l = 0; l < 2; l++) begin
        hv_nxt[i][l] = '0;
      end
    end
    for (int i = 1; i <= 10; i++) begin
      for (int l = 0; l < 2; l++) begin
        if ((i % 2) == 1) begin
          hv_nxt[i][l] = $signed(hv_r[i-1][l][32:0]) * $signed({1'b0, ht_r[i-1][l]});
        end else begin
          hv_nxt[i][l] = dotpi_pkg::HORNER_C[i/2-1] + (hv_r[i-1][l] >>> 30);
        end
      end
    end
    for (int l = 0; l < 2; l++) begin
      if (hv_r[10][l] < 0) begin
        cl[l] = '0;
      end else if (hv_r[10][l] > dotpi_pkg::Q30_ONE) begin
        cl[l] = 31'(dotpi_pkg::Q30_ONE);
      end else begin
        cl[l] = hv_r[10][l][30:0];
      end
      ent[l] = dotpi_pkg::INT_W'((32'(cl[l]) + 32'd8192) >> 14);
    end
    rnd = 19'((37'(prod_r) + 37'd131072) >> 18);
    sat = (rnd > 19'(dotpi_pkg::INT_ONE)) ? dotpi_pkg::INT_ONE : rnd[dotpi_pkg::INT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        kk_r[l]      <= kk_nxt[l];
        cneg_r[l]    <= quad[l][1] ^ quad[l][0];
        ht_r[0][l]   <= (31'(kk_r[l]) * 31'(kk_r[l])) << SH;
        hneg_r[0][l] <= cneg_r[l];
        hv_r[0][l]   <= dotpi_pkg::CO5_NEG;
        for (int i = 1; i <= 10; i++) begin
          ht_r[i][l]   <= ht_r[i-1][l];
          hneg_r[i][l] <= hneg_r[i-1][l];
          hv_r[i][l]   <= hv_nxt[i][l];
        end
        amp_r[l] <= hneg_r[10][l] ? (18'(dotpi_pkg::INT_ONE) - 18'(ent[l]))
                                  : (18'(dotpi_pkg::INT_ONE) + 18'(ent[l]));
      end
      prod_r <= amp_r[0] * amp_r[1];
      int_r  <= (ctl_r[ST_MP].gok && ctl_r[ST_MP].dot) ? sat : '0;
      ing_r  <= ctl_r[ST_MP].gok;
    end
  end

  logic ram_we, ram_rd;
  ctl_t ctl_dot;

  always_comb begin
    ctl_dot     = ctl_r[ST_C+1];
    ctl_dot.dot = ram_rd;
  end

  // Control travels with the data; the dot map bit joins two stages after the read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        ctl_r[i] <= '0;
      end
    end else if (adv) begin
      ctl_r[0] <= ctl_s0;
      for (int i = 1; i < NST; i++) begin
        if (i == ST_C) begin
          ctl_r[i] <= ctl_c;
        end else if (i == ST_C + 2) begin
          ctl_r[i] <= ctl_dot;
        end else begin
          ctl_r[i] <= ctl_r[i-1];
        end
      end
    end
  end

  assign ram_we = adv && ctl_r[ST_C].valid && !ctl_r[ST_C].query && ctl_r[ST_C].wok;

  dotpi_ram #(
    .W     (1),
    .DEPTH (DEPTH)
  ) u_dot_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ctl_r[ST_C].addr),
    .wdata (ctl_r[ST_C].wbit),
    .re    (adv),
    .raddr (ctl_r[ST_C].addr),
    .rdata (ram_rd)
  );

  assign out_res.valid     = ctl_r[ST_OUT].valid;
  assign out_res.intensity = int_r;
  assign out_res.in_grid   = ing_r;

`ifndef SYNTH
  a_zero_off_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.in_grid |-> out_res.intensity == '0)
    else $error("intensity nonzero outside grid");

  a_int_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> out_res.intensity <= dotpi_pkg::INT_ONE)
    else $error("intensity above one");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_req.valid && in_req.ready |=> ctl_r[0].valid)
    else $error("accepted word lost at entry");

  a_load_no_grid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[ST_OUT].valid && !ctl_r[ST_OUT].query |-> !ctl_r[ST_OUT].gok)
    else $error("load word flagged in grid");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |=> $stable(int_r) && $stable(ing_r) && out_res.valid)
    else $error("output word changed under stall");
`endif
endmodule

// ===== dv/dotpi_checker.sv =====
// Checker for the dot pattern core: watches both channels and the register port, predicts, compares.
`timescale 1ns / 100ps
module dotpi_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  dotpi_req_if                              req,
  dotpi_res_if                              res,
  input  logic                              cfg_we,
  input  logic [dotpi_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [dotpi_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                fail_count,
  output int                                pending
);
  localparam int MAP_COLS = dotpi_pkg::MAX_COLS_DEF;
  localparam int MAP_ROWS = dotpi_pkg::MAX_ROWS_DEF;
  localparam int PH_BITS  = dotpi_pkg::PHASE_BITS_DEF;
  localparam longint QSTEPS = longint'(1) << (PH_BITS - 2);
  localparam longint ONE_Q30 = longint'(1) << 30;

  typedef struct packed {
    logic [dotpi_pkg::INT_W-1:0] intensity;
    logic                        in_grid;
  } shade_t;

  shade_t shade_q[$];
  logic   dot_bits [MAP_ROWS*MAP_COLS];

  logic [dotpi_pkg::PERIOD_W-1:0]       m_period;
  logic [dotpi_pkg::EXT_W-1:0]          m_half_w, m_half_h;
  logic signed [dotpi_pkg::COORD_W-1:0] m_org_x, m_org_y;
  logic [dotpi_pkg::GRID_W-1:0]         m_rows, m_cols;

  function automatic longint floor_div(longint a, longint p);
    if (a >= 0) return a / p;
    return -(((-a) + p - 1) / p);
  endfunction

  function automatic longint mul_q30(longint a, longint t);
    longint prod;
    prod = a * t;
    if (prod >= 0) return prod >>> 30;
    return -(((-prod) + ONE_Q30 - 1) >>> 30);
  endfunction

  function automatic longint cos_entry(longint k);
    longint t, acc;
    t = (k * k) << (30 - 2 * (PH_BITS - 2));
    acc = -27060;
    acc = 987049 + mul_q30(acc, t);
    acc = -22401991 + mul_q30(acc, t);
    acc = 272375562 + mul_q30(acc, t);
    acc = -1324675880 + mul_q30(acc, t);
    acc = ONE_Q30 + mul_q30(acc, t);
    if (acc < 0) acc = 0;
    if (acc > ONE_Q30) acc = ONE_Q30;
    return (acc + 8192) >>> 14;
  endfunction

  // 1 + cos(2*pi*c/p) in Q16; the phase ignores the origin.
  function automatic longint lifted_cos(longint c, longint p);
    longint r, ph, k, cv;
    int quad;
    r = c - floor_div(c, p) * p;
    ph = (r << PH_BITS) / p;
    quad = int'((ph >> (PH_BITS - 2)) & 3);
    k = ph & (QSTEPS - 1);
    case (quad)
      0: cv = cos_entry(k);
      1: cv = -cos_entry(QSTEPS - k);
      2: cv = -cos_entry(k);
      default: cv = cos_entry(QSTEPS - k);
    endcase
    return 65536 + cv;
  endfunction

  function automatic shade_t shade_at(logic signed [dotpi_pkg::COORD_W-1:0] xs,
                                      logic signed [dotpi_pkg::COORD_W-1:0] ys);
    shade_t s;
    longint x, y, p, hw, hh, rl, cl, col, row, prod;
    s = '0;
    x = xs; y = ys; p = m_period; hw = m_half_w; hh = m_half_h;
    rl = (m_rows < MAP_ROWS) ? m_rows : MAP_ROWS;
    cl = (m_cols < MAP_COLS) ? m_cols : MAP_COLS;
    if (p == 0) return s;
    if (x < -hw || x > hw || y < -hh || y > hh) return s;
    col = floor_div(x + longint'(m_org_x), p);
    row = floor_div(y + longint'(m_org_y), p);
    if (col < 0 || row < 0 || col >= cl || row >= rl) return s;
    s.in_grid = 1'b1;
    if (!dot_bits[row*MAP_COLS + col]) return s;
    prod = (lifted_cos(x, p) * lifted_cos(y, p) + (longint'(1) << 17)) >>> 18;
    if (prod > 65536) prod = 65536;
    s.intensity = prod[dotpi_pkg::INT_W-1:0];
    return s;
  endfunction

  always @(posedge clk) begin
    shade_t got, want;
    if (!rst_n) begin
      m_period <= dotpi_pkg::PERIOD_RST;
      m_half_w <= dotpi_pkg::HALF_RST;
      m_half_h <= dotpi_pkg::HALF_RST;
      m_org_x  <= '0;
      m_org_y  <= '0;
      m_rows   <= dotpi_pkg::GRID_RST;
      m_cols   <= dotpi_pkg::GRID_RST;
      shade_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          dotpi_pkg::REG_PERIOD:      m_period <= cfg_data[dotpi_pkg::PERIOD_W-1:0];
          dotpi_pkg::REG_HALF_WIDTH:  m_half_w <= cfg_data[dotpi_pkg::EXT_W-1:0];
          dotpi_pkg::REG_HALF_HEIGHT: m_half_h <= cfg_data[dotpi_pkg::EXT_W-1:0];
          dotpi_pkg::REG_ORIGIN_X:    m_org_x  <= cfg_data[dotpi_pkg::COORD_W-1:0];
          dotpi_pkg::REG_ORIGIN_Y:    m_org_y  <= cfg_data[dotpi_pkg::COORD_W-1:0];
          dotpi_pkg::REG_GRID_ROWS:   m_rows   <= cfg_data[dotpi_pkg::GRID_W-1:0];
          dotpi_pkg::REG_GRID_COLS:   m_cols   <= cfg_data[dotpi_pkg::GRID_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (!req.req_type) begin
          dot_bits[req.row_index*MAP_COLS + req.col_index] = req.bit_value;
          shade_q = {shade_q, shade_t'('0)};
        end else begin
          shade_q = {shade_q, shade_at(req.x_pos, req.y_pos)};
        end
      end
      if (res.valid && res.ready) begin
        got.intensity = res.intensity;
        got.in_grid   = res.in_grid;
        if (shade_q.size() == 0) begin
          $error("result word with nothing expected: intensity %0d in_grid %0d",
                 got.intensity, got.in_grid);
          fail_count++;
        end else begin
          want = shade_q.pop_front();
          if (got.intensity !== want.intensity) begin
            $error("intensity: expected %0d, actual %0d", want.intensity, got.intensity);
            fail_count++;
          end
          if (got.in_grid !== want.in_grid) begin
            $error("in_grid: expected %0d, actual %0d", want.in_grid, got.in_grid);
            fail_count++;
          end
        end
      end
    end
    pending = shade_q.size();
  end
endmodule

// ===== dv/dot_pattern_intensity_core_tb.sv =====
// Top of the dot pattern core testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module dot_pattern_intensity_core_tb;

  localparam logic [dotpi_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk, rst_n;
  logic cfg_we;
  logic [dotpi_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [dotpi_pkg::CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending;
  int accepted_out;
  bit hold_done;

  dotpi_req_if req_if ();
  dotpi_res_if res_if ();

  dot_pattern_intensity_core dut (
    .clk(clk), .rst_n(rst_n), .in_req(req_if.sink), .out_res(res_if.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  dotpi_checker chk (
    .clk(clk), .rst_n(rst_n), .req(req_if), .res(res_if),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Stimulus-side copy of the geometry, used to aim queries and to load a cell before it is read.
  int t_period, t_org_x, t_org_y, t_rows, t_cols, t_hw, t_hh;
  bit t_live;
  bit burst_mode;
  bit written [64*64];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(logic kind, logic [5:0] row, logic [5:0] col, logic bitv,
                           logic [23:0] x, logic [23:0] y);
    int g;
    @(negedge clk);
    req_if.valid     = 1'b1;
    req_if.req_type  = kind;
    req_if.row_index = row;
    req_if.col_index = col;
    req_if.bit_value = bitv;
    req_if.x_pos     = x;
    req_if.y_pos     = y;
    do @(posedge clk); while (!req_if.ready);
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      req_if.valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic load_cell(int row, int col, logic bitv);
    written[row*64 + col] = 1'b1;
    send_word(1'b0, row[5:0], col[5:0], bitv, 24'($urandom()), 24'($urandom()));
  endtask

  // True when the query lands on a grid cell that has never been loaded.
  function automatic bit cell_unwritten(int x, int y, output int row, output int col);
    longint xs, ys, cx, cy, p;
    xs = longint'($signed(x[23:0]));
    ys = longint'($signed(y[23:0]));
    row = 0;
    col = 0;
    if (!t_live) return 1'b0;
    if (xs < -t_hw || xs > t_hw || ys < -t_hh || ys > t_hh) return 1'b0;
    p  = t_period;
    cx = xs + t_org_x;
    cy = ys + t_org_y;
    cx = (cx >= 0) ? cx / p : -(((-cx) + p - 1) / p);
    cy = (cy >= 0) ? cy / p : -(((-cy) + p - 1) / p);
    if (cx < 0 || cy < 0 || cx >= t_cols || cy >= t_rows) return 1'b0;
    col = int'(cx);
    row = int'(cy);
    return !written[row*64 + col];
  endfunction

  task automatic query_at(int x, int y);
    int row, col;
    if (cell_unwritten(x, y, row, col))
      load_cell(row, col, 1'($urandom()));
    send_word(1'b1, 6'($urandom()), 6'($urandom()), 1'($urandom()), x[23:0], y[23:0]);
  endtask

  // Mostly a cell in a small window, sometimes just outside either end of the grid.
  function automatic int aim_coord(int org, int lim);
    int slot, pick, win;
    pick = $urandom_range(0, 9);
    win  = (lim > 8) ? 8 : lim;
    if (pick == 0)
      slot = -1;
    else if (pick == 1 || win == 0)
      slot = lim;
    else
      slot = $urandom_range(0, win - 1);
    return slot * t_period - org + $urandom_range(0, t_period - 1);
  endfunction

  task automatic settle();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [dotpi_pkg::CFG_IDX_W-1:0] idx, int data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data[dotpi_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_geometry(int p, int hw, int hh, int ox, int oy, int rows, int cols);
    settle();
    write_reg(dotpi_pkg::REG_PERIOD, p);
    write_reg(dotpi_pkg::REG_HALF_WIDTH, hw);
    write_reg(dotpi_pkg::REG_HALF_HEIGHT, hh);
    write_reg(dotpi_pkg::REG_ORIGIN_X, ox);
    write_reg(dotpi_pkg::REG_ORIGIN_Y, oy);
    write_reg(dotpi_pkg::REG_GRID_ROWS, rows);
    write_reg(dotpi_pkg::REG_GRID_COLS, cols);
    t_period = (p == 0) ? 1 : p;
    t_live = (p != 0);
    t_hw = hw; t_hh = hh;
    t_org_x = ox; t_org_y = oy;
    t_rows = (rows > 64) ? 64 : rows;
    t_cols = (cols > 64) ? 64 : cols;
  endtask

  task automatic random_words(int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r % 25 == 0) burst_mode = ~burst_mode;
      if (r < 15)
        load_cell($urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom()));
      else if (r < 80)
        query_at(aim_coord(t_org_x, t_cols), aim_coord(t_org_y, t_rows));
      else
        query_at(int'($urandom()), int'($urandom()));
    end
  endtask

  // Receiver: random stalls, plus one long hold-off so the pipeline fills and stalls its input.
  initial begin
    int g;
    res_if.ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && accepted_out > 250) begin
        hold_done = 1'b1;
        res_if.ready = 1'b0;
        repeat (300) @(negedge clk);
      end
      g = pick_gap();
      if (g == 0) begin
        res_if.ready = 1'b1;
      end else begin
        res_if.ready = 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) if (res_if.valid && res_if.ready) accepted_out++;

  initial begin
    accepted_out = 0;
    burst_mode = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    req_if.valid = 1'b0; req_if.req_type = 1'b0; req_if.row_index = '0;
    req_if.col_index = '0; req_if.bit_value = 1'b0; req_if.x_pos = '0; req_if.y_pos = '0;
    t_period = 256; t_org_x = 0; t_org_y = 0; t_rows = 1; t_cols = 1;
    t_hw = 8388607; t_hh = 8388607; t_live = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words under the reset geometry.
    load_cell(0, 0, 1'b1);
    query_at(0, 0);
    query_at(128, 128);
    query_at(64, 192);
    query_at(255, 255);
    query_at(-1, 0);
    query_at(256, 0);
    query_at(32'h7FFFFF, 32'h7FFFFF);
    query_at(-8388608, -8388608);
    load_cell(0, 0, 1'b0);
    query_at(128, 128);
    load_cell(63, 63, 1'b1);
    load_cell(0, 0, 1'b1);
    query_at(1, 255);
    random_words(150);

    set_geometry(256, 8388607, 8388607, 0, 0, 64, 64);
    query_at(63 * 256 + 128, 63 * 256 + 128);
    query_at(64 * 256, 0);
    random_words(200);

    // Unused register index must be ignored.
    settle();
    write_reg(REG_UNUSED, 24'hFFFFFF);
    set_geometry(1, 100, 100, -20, -20, 64, 64);
    query_at(100, 100);
    query_at(-100, -100);
    query_at(101, 0);
    random_words(200);

    set_geometry(65535, 8388607, 8388607, -8388608, 8388607, 127, 127);
    random_words(200);

    set_geometry(0, 8388607, 8388607, 0, 0, 64, 64);
    query_at(0, 0);
    random_words(60);

    set_geometry(37, 0, 0, 5, 5, 0, 3);
    query_at(0, 0);
    random_words(80);

    set_geometry(300, 5000, 3000, 1000, -500, 17, 40);
    query_at(5000, -3000);
    query_at(-5000, 3000);
    random_words(350);

    settle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
